/* rtl/kuf_pkg.sv */
// ----------------------------------------------------------------------------
// kuf_pkg
// Shared types and constants for the union-find edge filter: edge and result
// payloads, sequencer states and the parent store command bundle.
// ----------------------------------------------------------------------------
package kuf_pkg;

   localparam int unsigned VERTEX_BITS       = 7;
   localparam int unsigned WEIGHT_FIELD_BITS = 15;
   localparam int unsigned VERTEX_SPACE      = 1 << VERTEX_BITS;
   localparam int unsigned MAX_VERTICES_DEF  = 128;
   localparam int unsigned WEIGHT_BITS_DEF   = 15;

   typedef logic [VERTEX_BITS-1:0] kuf_vertex_type;

   typedef struct packed {
      logic [VERTEX_BITS-1:0]       edge_from;
      logic [VERTEX_BITS-1:0]       edge_to;
      logic [WEIGHT_FIELD_BITS-1:0] edge_weight;
      logic                         last_edge;
   } kuf_req_type;

   typedef struct packed {
      logic                         accepted;
      logic [VERTEX_BITS-1:0]       out_from;
      logic [VERTEX_BITS-1:0]       out_to;
      logic [WEIGHT_FIELD_BITS-1:0] out_weight;
      logic                         out_last;
   } kuf_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK_A,
      ST_WALK_B,
      ST_JOIN,
      ST_FINISH
   } kuf_state_type;

   // One command per cycle to the parent store
   typedef struct packed {
      logic           rd_en;
      logic           wr_en;
      logic           clear;
      kuf_vertex_type addr;
      kuf_vertex_type wr_data;
   } kuf_mem_cmd_type;

endpackage

/* rtl/kuf_store.sv */
// ----------------------------------------------------------------------------
// kuf_store
// Union-find parent store: single-port memory with registered read and one
// root flag per vertex. A vertex whose flag is clear reads as its own parent.
// ----------------------------------------------------------------------------
module kuf_store #(
   parameter int unsigned DEPTH = kuf_pkg::MAX_VERTICES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  kuf_pkg::kuf_mem_cmd_type  mem_cmd,
   output kuf_pkg::kuf_vertex_type   rd_parent
);
   import kuf_pkg::*;

   localparam int unsigned AW = $clog2(DEPTH);

   logic [AW-1:0]    mem [DEPTH];
   logic [DEPTH-1:0] linked_ff;
   logic [DEPTH-1:0] linked_in;
   logic [AW-1:0]    rd_data_ff;
   logic [AW-1:0]    rd_addr_ff;
   logic             rd_linked_ff;
   logic [AW-1:0]    addr;

   assign addr = mem_cmd.addr[AW-1:0];

   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         mem[addr] <= mem_cmd.wr_data[AW-1:0];
      end
      if (mem_cmd.rd_en) begin
         rd_data_ff   <= mem[addr];
         rd_addr_ff   <= addr;
         rd_linked_ff <= linked_ff[addr];
      end
   end

   // Clear wins over a link in the same cycle: the forest is dropped anyway
   always_comb begin
      linked_in = linked_ff;
      if (mem_cmd.clear) begin
         linked_in = '0;
      end else if (mem_cmd.wr_en) begin
         linked_in[addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         linked_ff <= '0;
      end else begin
         linked_ff <= linked_in;
      end
   end

   assign rd_parent = VERTEX_BITS'(rd_linked_ff ? rd_data_ff : rd_addr_ff);

endmodule

/* rtl/kuf_ctrl.sv */
// ----------------------------------------------------------------------------
// kuf_ctrl
// Root-walk sequencer. One comparator is shared between the parent-link
// walks of both endpoints and the final root compare.
// ----------------------------------------------------------------------------
module kuf_ctrl #(
   parameter int unsigned MAX_VERTICES = kuf_pkg::MAX_VERTICES_DEF,
   parameter int unsigned WEIGHT_BITS  = kuf_pkg::WEIGHT_BITS_DEF,
   parameter int unsigned DEPTH        = kuf_pkg::MAX_VERTICES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  kuf_pkg::kuf_req_type      req_payload,
   input  logic                      out_free,
   output logic                      rsp_load,
   output kuf_pkg::kuf_rsp_type      rsp_next,
   output kuf_pkg::kuf_mem_cmd_type  mem_cmd,
   input  kuf_pkg::kuf_vertex_type   rd_parent
);
   import kuf_pkg::*;

   localparam int unsigned WKEEP = (WEIGHT_BITS < WEIGHT_FIELD_BITS) ?
                                   WEIGHT_BITS : WEIGHT_FIELD_BITS;
   localparam logic [WEIGHT_FIELD_BITS-1:0] WMASK =
      WEIGHT_FIELD_BITS'((64'd1 << WKEEP) - 64'd1);

   kuf_state_type  state_ff, state_in;
   kuf_req_type    edge_ff, edge_in;
   kuf_vertex_type cur_ff, cur_in;
   kuf_vertex_type ra_ff, ra_in;
   logic           acc_ff, acc_in;

   logic           in_range;
   kuf_vertex_type cmp_a;
   logic           same;

   assign in_range = (32'(req_payload.edge_from) < MAX_VERTICES) &&
                     (32'(req_payload.edge_to) < MAX_VERTICES);

   // Shared comparator: parent vs. current during walks, root A vs. root B at join
   always_comb begin
      unique case (state_ff)
         ST_JOIN: cmp_a = ra_ff;
         default: cmp_a = rd_parent;
      endcase
   end
   assign same = (cmp_a == cur_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = in_range ? ST_WALK_A : ST_FINISH;
            end
         end
         ST_WALK_A: begin
            if (same) begin
               state_in = ST_WALK_B;
            end
         end
         ST_WALK_B: begin
            if (same) begin
               state_in = ST_JOIN;
            end
         end
         ST_JOIN:   state_in = ST_FINISH;
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      mem_cmd   = '0;
      edge_in   = edge_ff;
      cur_in    = cur_ff;
      ra_in     = ra_ff;
      acc_in    = acc_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               edge_in       = req_payload;
               cur_in        = req_payload.edge_from;
               acc_in        = 1'b0;
               mem_cmd.rd_en = in_range;
               mem_cmd.addr  = req_payload.edge_from;
            end
         end
         ST_WALK_A: begin
            mem_cmd.rd_en = 1'b1;
            if (same) begin
               // root of the first endpoint found; start on the second
               ra_in        = cur_ff;
               cur_in       = edge_ff.edge_to;
               mem_cmd.addr = edge_ff.edge_to;
            end else begin
               cur_in       = rd_parent;
               mem_cmd.addr = rd_parent;
            end
         end
         ST_WALK_B: begin
            if (!same) begin
               mem_cmd.rd_en = 1'b1;
               mem_cmd.addr  = rd_parent;
               cur_in        = rd_parent;
            end
         end
         ST_JOIN: begin
            acc_in = !same;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_load        = 1'b1;
               mem_cmd.wr_en   = acc_ff;
               mem_cmd.addr    = ra_ff;
               mem_cmd.wr_data = cur_ff;
               mem_cmd.clear   = edge_ff.last_edge;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      edge_ff <= edge_in;
      cur_ff  <= cur_in;
      ra_ff   <= ra_in;
      acc_ff  <= acc_in;
   end

   always_comb begin
      rsp_next.accepted   = acc_ff;
      rsp_next.out_from   = edge_ff.edge_from;
      rsp_next.out_to     = edge_ff.edge_to;
      rsp_next.out_weight = edge_ff.edge_weight & WMASK;
      rsp_next.out_last   = edge_ff.last_edge;
   end

`ifndef ASSERT_OFF
   // Only distinct roots are ever linked
   a_link_distinct: assert property (@(posedge clock) disable iff (reset)
      mem_cmd.wr_en |-> (ra_ff != cur_ff))
      else $error("link between equal roots");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> out_free)
      else $error("result loaded while output register full");

   a_parent_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK_A || state_ff == ST_WALK_B) |-> (32'(rd_parent) < DEPTH))
      else $error("parent link outside store");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != ST_IDLE))
      else $error("sequencer idle after edge transfer");
`endif

endmodule

/* rtl/kruskal_union_find_edge_filter.sv */
// ----------------------------------------------------------------------------
// kruskal_union_find_edge_filter
// Edge acceptance stage of a minimum spanning tree flow over a union-find
// parent store.
//
// Usage:
//   req_* carries one edge per transfer (valid/ready). Edges are expected in
//   nondecreasing weight order; the weight is only echoed, masked to WEIGHT_BITS.
//   rsp_* returns exactly one result per edge: accepted is set when the edge
//   joins two separate trees, and the edge fields are echoed.
//   An edge with last_edge set clears the forest once its result is loaded.
//   Each edge walks da and db parent links from its endpoints to their
//   roots; each link is one read of the single-port store. A new edge is
//   taken only after the previous result has been loaded. The result is
//   registered and appears in the cycle after the sequencer finishes. An edge
//   with an endpoint outside the vertex range is rejected without a walk.
//   A full output register holds the sequencer in its last state until
//   rsp_ready frees it; req_ready stays low meanwhile.
//   Reset clears all root flags at once, so every vertex is its own root; no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
module kruskal_union_find_edge_filter #(
   parameter int unsigned MAX_VERTICES = kuf_pkg::MAX_VERTICES_DEF,
   parameter int unsigned WEIGHT_BITS  = kuf_pkg::WEIGHT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  kuf_pkg::kuf_req_type  req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output kuf_pkg::kuf_rsp_type  rsp_payload
);
   import kuf_pkg::*;

   // Vertex indices are 7 bits wide, so no more entries can ever be reached
   localparam int unsigned DEPTH = (MAX_VERTICES < VERTEX_SPACE) ?
                                   MAX_VERTICES : VERTEX_SPACE;

   kuf_mem_cmd_type mem_cmd;
   kuf_vertex_type  rd_parent;
   kuf_rsp_type     rsp_next;
   logic            rsp_load;
   logic            out_free;
   logic            rsp_valid_ff, rsp_valid_in;
   kuf_rsp_type     rsp_payload_ff, rsp_payload_in;

   assign out_free = !rsp_valid_ff || rsp_ready;

   kuf_ctrl #(
      .MAX_VERTICES (MAX_VERTICES),
      .WEIGHT_BITS  (WEIGHT_BITS),
      .DEPTH        (DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .out_free    (out_free),
      .rsp_load    (rsp_load),
      .rsp_next    (rsp_next),
      .mem_cmd     (mem_cmd),
      .rd_parent   (rd_parent)
   );

   kuf_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .mem_cmd   (mem_cmd),
      .rd_parent (rd_parent)
   );

   // Output register: load a finished result, drop it on transfer
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (rsp_load) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = rsp_next;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the union-find edge filter. Edges go in through a
// valid/ready driver fed from a queue; a local forest model predicts the
// accept/reject verdict and echoed fields of every transfer, and a monitor
// compares each result against the oldest prediction. Both channels idle at
// random, the receiver takes one long hold-off and the sender drains now and
// then.
// ----------------------------------------------------------------------------
module tb_top;
   import kuf_pkg::*;

   localparam int unsigned CYCLE_LIMIT      = 1_500_000;
   localparam int unsigned SETTLE_CYCLES    = 400;
   localparam int unsigned LONG_HOLD_CYCLES = 600;
   localparam int unsigned LONG_HOLD_AFTER  = 300;
   localparam int unsigned RANDOM_EDGES     = 1050;
   localparam int unsigned DRAIN_SPACING    = 350;
   localparam int unsigned WEIGHT_MAX       = (1 << WEIGHT_FIELD_BITS) - 1;

   typedef struct {
      kuf_req_type payload;
      bit          drain;
   } queued_edge_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   kuf_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   kuf_rsp_type rsp_payload;

   kuf_vertex_type  forest_parent [VERTEX_SPACE];
   queued_edge_type pending_edges [$];
   kuf_rsp_type     expected_results [$];

   int unsigned edges_sent   = 0;
   int unsigned results_seen = 0;
   int unsigned error_count  = 0;
   int unsigned cycle_count  = 0;
   int unsigned edges_queued = 0;
   bit          drain_next   = 1'b0;

   kruskal_union_find_edge_filter uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------- forest

   function automatic void clear_forest();
      for (int v = 0; v < VERTEX_SPACE; v++) begin
         forest_parent[v] = kuf_vertex_type'(v);
      end
   endfunction

   function automatic kuf_vertex_type forest_root(kuf_vertex_type v);
      kuf_vertex_type node;
      node = v;
      for (int step = 0; step < MAX_VERTICES_DEF; step++) begin
         if (forest_parent[node] == node) break;
         node = forest_parent[node];
      end
      return node;
   endfunction

   // Join the two trees if they differ, then clear after the final edge
   function automatic kuf_rsp_type filter_edge(kuf_req_type e);
      kuf_vertex_type root_from;
      kuf_vertex_type root_to;
      kuf_rsp_type    verdict;
      verdict.accepted = 1'b0;
      if (e.edge_from < MAX_VERTICES_DEF && e.edge_to < MAX_VERTICES_DEF) begin
         root_from = forest_root(e.edge_from);
         root_to   = forest_root(e.edge_to);
         if (root_from != root_to) begin
            forest_parent[root_from] = root_to;
            verdict.accepted = 1'b1;
         end
      end
      verdict.out_from   = e.edge_from;
      verdict.out_to     = e.edge_to;
      verdict.out_weight = e.edge_weight;
      verdict.out_last   = e.last_edge;
      if (e.last_edge) clear_forest();
      return verdict;
   endfunction

   // ------------------------------------------------------------- utilities

   function automatic int unsigned gap_cycles(bit no_idle);
      int unsigned pick;
      pick = $urandom_range(99, 0);
      if (no_idle || pick < 55) return 0;
      if (pick < 85) return $urandom_range(3, 1);
      if (pick < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   task automatic add_edge(int unsigned from_v, int unsigned to_v, int unsigned weight,
                           bit last);
      queued_edge_type entry;
      entry.payload.edge_from   = kuf_vertex_type'(from_v);
      entry.payload.edge_to     = kuf_vertex_type'(to_v);
      entry.payload.edge_weight = weight[WEIGHT_FIELD_BITS-1:0];
      entry.payload.last_edge   = last;
      entry.drain               = drain_next;
      drain_next                = 1'b0;
      pending_edges.push_back(entry);
      edges_queued++;
   endtask

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin : edge_driver
      logic        next_valid;
      kuf_req_type next_payload;
      int unsigned send_gap;
      if (reset) begin
         req_valid   <= 1'b0;
         req_payload <= '0;
         send_gap = 0;
         clear_forest();
      end else begin
         next_valid   = req_valid;
         next_payload = req_payload;
         if (req_valid && req_ready) begin
            expected_results.push_back(filter_edge(req_payload));
            edges_sent++;
            next_valid = 1'b0;
            send_gap   = gap_cycles((edges_sent / 128) % 3 == 2);
         end
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_edges.size() > 0 &&
                         (!pending_edges[0].drain || results_seen == edges_sent)) begin
               next_payload = pending_edges[0].payload;
               next_valid   = 1'b1;
               pending_edges.delete(0);
            end
         end
         req_valid   <= next_valid;
         req_payload <= next_payload;
      end
   end

   // --------------------------------------------------------------- monitor

   always @(posedge clock) begin : result_monitor
      kuf_rsp_type want;
      int unsigned seen;
      int unsigned stall_left;
      int unsigned hold_left;
      bit          long_hold_done;
      if (reset) begin
         rsp_ready    <= 1'b0;
         results_seen <= 0;
         stall_left     = 0;
         hold_left      = 0;
         long_hold_done = 1'b0;
      end else begin
         seen = results_seen;
         if (rsp_valid && rsp_ready) begin
            seen++;
            if (expected_results.size() == 0) begin
               $error("unexpected result: from %0d to %0d", rsp_payload.out_from,
                      rsp_payload.out_to);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               compare_field("accepted", 32'(want.accepted), 32'(rsp_payload.accepted));
               compare_field("out_from", 32'(want.out_from), 32'(rsp_payload.out_from));
               compare_field("out_to", 32'(want.out_to), 32'(rsp_payload.out_to));
               compare_field("out_weight", 32'(want.out_weight),
                             32'(rsp_payload.out_weight));
               compare_field("out_last", 32'(want.out_last), 32'(rsp_payload.out_last));
            end
         end
         results_seen <= seen;
         // Hold off long enough for the block to fill and stall its input
         if (!long_hold_done && seen >= LONG_HOLD_AFTER) begin
            hold_left      = LONG_HOLD_CYCLES;
            long_hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(99, 0) < 20) stall_left = gap_cycles((seen / 100) % 4 == 3);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ------------------------------------------------------------- stimulus

   initial begin : stimulus
      int unsigned vertex_ids [128];
      int unsigned kind;
      int unsigned n;
      int unsigned count;
      int unsigned weight;
      int unsigned base;
      int unsigned chains_built;
      int unsigned next_drain;
      int unsigned random_start;

      // Directed: self loops, cycles, the extreme vertices and weights,
      // clearing after the final edge, unsorted weights
      add_edge(0, 0, 0, 1'b0);
      add_edge(0, 1, 1, 1'b0);
      add_edge(1, 2, 2, 1'b0);
      add_edge(2, 3, 3, 1'b0);
      add_edge(3, 0, 4, 1'b0);
      add_edge(127, 126, 5, 1'b0);
      add_edge(126, 127, 6, 1'b0);
      add_edge(0, 127, 7, 1'b0);
      add_edge(127, 127, 8, 1'b0);
      add_edge(3, 126, 9, 1'b0);
      add_edge(85, 42, WEIGHT_MAX, 1'b0);
      add_edge(42, 85, 100, 1'b1);
      add_edge(1, 0, WEIGHT_MAX, 1'b0);
      add_edge(0, 1, 0, 1'b1);
      add_edge(1, 0, 0, 1'b1);
      add_edge(127, 0, 16383, 1'b1);
      add_edge(42, 85, 21845, 1'b0);
      add_edge(85, 42, 10922, 1'b1);

      drain_next   = 1'b1;
      chains_built = 0;
      random_start = edges_queued;
      next_drain   = edges_queued + DRAIN_SPACING;
      while (edges_queued - random_start < RANDOM_EDGES) begin
         if (edges_queued >= next_drain) begin
            drain_next = 1'b1;
            next_drain = edges_queued + DRAIN_SPACING;
         end
         kind = $urandom_range(99, 0);
         if (kind < 4 && chains_built < 2) begin
            // Long chain, then walks from its far ends
            chains_built++;
            n      = $urandom_range(128, 96);
            base   = $urandom_range(127, 0);
            weight = $urandom_range(1000, 0);
            for (int i = 0; i < n; i++) vertex_ids[i] = (base + i) % 128;
            for (int i = 0; i + 1 < n; i++) begin
               add_edge(vertex_ids[i], vertex_ids[i+1], weight, 1'b0);
               weight += $urandom_range(3, 0);
            end
            add_edge(vertex_ids[0], vertex_ids[n-1], weight, 1'b0);
            add_edge(vertex_ids[n-1], vertex_ids[0], weight, 1'b0);
            add_edge(vertex_ids[1], vertex_ids[n-2], weight + 1, 1'b0);
            add_edge(vertex_ids[0], vertex_ids[0], weight + 2, 1'b1);
         end else if (kind < 14) begin
            // Noise: unsorted weights, any endpoints, stray final markers
            count = $urandom_range(12, 1);
            for (int i = 0; i < count; i++) begin
               add_edge($urandom_range(127, 0), $urandom_range(127, 0),
                        $urandom_range(WEIGHT_MAX, 0), $urandom_range(3, 0) == 0);
            end
         end else begin
            // Well-formed graph over a random vertex subset
            n = ($urandom_range(99, 0) < 85) ? $urandom_range(12, 2) : $urandom_range(64, 13);
            for (int i = 0; i < n; i++) vertex_ids[i] = $urandom_range(127, 0);
            count  = $urandom_range(2 * n, 1);
            weight = ($urandom_range(3, 0) == 0) ? WEIGHT_MAX - $urandom_range(200, 0)
                                                 : $urandom_range(WEIGHT_MAX, 0);
            for (int i = 0; i < count; i++) begin
               add_edge(vertex_ids[$urandom_range(n - 1, 0)],
                        vertex_ids[$urandom_range(n - 1, 0)], weight, i == count - 1);
               weight += $urandom_range(40, 0);
               if (weight > WEIGHT_MAX) weight = WEIGHT_MAX;
            end
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_edges.size() != 0 || req_valid) @(posedge clock);
      while (results_seen != edges_sent) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (expected_results.size() != 0) begin
         $error("%0d results never arrived", expected_results.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/kuf_pkg.sv
rtl/kuf_store.sv
rtl/kuf_ctrl.sv
rtl/kruskal_union_find_edge_filter.sv
tb/tb_top.sv
